// ===== hdl/bfd_pkg.sv =====
// ---------------------------------------------------------------------------
// bfd_pkg: shared types and constants for the bus frame deframer
// Result kinds, length limits, register map and field widths.
// ---------------------------------------------------------------------------
package bfd_pkg;

  localparam int BYTE_W = 8;
  localparam int KIND_W = 3;

  // Output tdata carries eight byte-wide fields
  localparam int OUT_DATA_W = 8 * BYTE_W;

  // Body length limits, inclusive
  localparam logic [BYTE_W-1:0] MIN_LENGTH = 8'd3;
  localparam logic [BYTE_W-1:0] MAX_LENGTH = 8'd123;

  // Register reset values
  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h4A;
  localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'h3B;

  // Register map: one register per 32-bit word
  localparam int ADDR_W = 3;
  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_TAIL   = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_BODY     = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_BAD_SUM  = 3'd2,
    KIND_BAD_TAIL = 3'd3,
    KIND_BAD_LEN  = 3'd4
  } kind_t;

endpackage

// ===== hdl/bus_frame_deframer_checksum.sv =====
// ---------------------------------------------------------------------------
// bus_frame_deframer_checksum: bus frame deframer with body checksum
// Hunts for a header, takes length, body, checksum and tail bytes, emits
// each body byte and one status item per frame.
// ---------------------------------------------------------------------------
// Results: each accepted input item that causes a result is registered in the
//   output register (items that cause no result leave nothing there).
// Throughput: one item per cycle; the per-byte state update is a single
//   add and compare, and the output register lets input flow while a result
//   waits, as long as the sink takes it in the same cycle.
// Reset (rst, synchronous): back to the header hunt, frame state cleared,
//   output empty, header and tail registers at 0x4A and 0x3B.
module bus_frame_deframer_checksum (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bfd_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Received bytes
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bfd_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
  // Results
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bfd_pkg::OUT_DATA_W-1:0] m_tdata,  // [7:0] body_index,
                                                   // [15:8] body_byte,
                                                   // [23:16] control_field,
                                                   // [31:24] station_id,
                                                   // [39:32] command_code,
                                                   // [47:40] body_length,
                                                   // [55:48] length_upper,
                                                   // [63:56] computed_sum
  output logic [bfd_pkg::KIND_W-1:0]    m_tuser    // [2:0] kind
);
  import bfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LENHI,
    PH_LEN,
    PH_BODY,
    PH_SUM,
    PH_TAIL
  } phase_t;

  // Configuration registers
  logic [BYTE_W-1:0] header_byte;
  logic [BYTE_W-1:0] tail_byte;

  // Frame state
  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] len_hi_seen, len_hi_seen_next;
  logic [BYTE_W-1:0] len_seen, len_seen_next;
  logic [BYTE_W-1:0] bytes_taken, bytes_taken_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;
  logic [BYTE_W-1:0] sum_received, sum_received_next;
  logic [BYTE_W-1:0] ctrl_seen, ctrl_seen_next;
  logic [BYTE_W-1:0] id_seen, id_seen_next;
  logic [BYTE_W-1:0] cmd_seen, cmd_seen_next;

  // Result produced by the current item
  logic              emit;
  kind_t             kind_next;
  logic [BYTE_W-1:0] index_next;
  logic [BYTE_W-1:0] body_next;

  logic              in_accept;
  logic              out_take;
  logic [BYTE_W-1:0] rx_byte;

  // ---- Configuration port ------------------------------------------------
  // Decode only the word select bit; writes land at the access cycle.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= HEADER_RESET;
      tail_byte   <= TAIL_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_HEADER) begin
        header_byte <= pwdata[BYTE_W-1:0];
      end else begin
        tail_byte <= pwdata[BYTE_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_HEADER) begin
      prdata[BYTE_W-1:0] = header_byte;
    end else begin
      prdata[BYTE_W-1:0] = tail_byte;
    end
  end

  // ---- Handshakes --------------------------------------------------------
  // Take a new byte whenever the output register is empty or drains now.
  assign s_tready  = !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;
  assign out_take  = m_tvalid && m_tready;
  assign rx_byte   = s_tdata;

  // ---- Per-byte frame logic ----------------------------------------------
  always_comb begin
    phase_next        = phase;
    len_hi_seen_next  = len_hi_seen;
    len_seen_next     = len_seen;
    bytes_taken_next  = bytes_taken;
    running_sum_next  = running_sum;
    sum_received_next = sum_received;
    ctrl_seen_next    = ctrl_seen;
    id_seen_next      = id_seen;
    cmd_seen_next     = cmd_seen;
    emit              = 1'b0;
    kind_next         = KIND_BODY;
    index_next        = '0;
    body_next         = '0;

    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == header_byte) begin
          phase_next = PH_LENHI;
        end
      end
      PH_LENHI: begin
        // High length byte is only passed through
        len_hi_seen_next = rx_byte;
        phase_next       = PH_LEN;
      end
      PH_LEN: begin
        // Start a fresh frame; flag a bad length at once
        len_seen_next     = rx_byte;
        bytes_taken_next  = '0;
        running_sum_next  = '0;
        sum_received_next = '0;
        ctrl_seen_next    = '0;
        id_seen_next      = '0;
        cmd_seen_next     = '0;
        if (rx_byte < MIN_LENGTH || rx_byte > MAX_LENGTH) begin
          phase_next = PH_HUNT;
          emit       = 1'b1;
          kind_next  = KIND_BAD_LEN;
        end else begin
          phase_next = PH_BODY;
        end
      end
      PH_BODY: begin
        // Capture the three header fields of the body, sum every byte
        if (bytes_taken == 8'd0) begin
          ctrl_seen_next = rx_byte;
        end
        if (bytes_taken == 8'd1) begin
          id_seen_next = rx_byte;
        end
        if (bytes_taken == 8'd2) begin
          cmd_seen_next = rx_byte;
        end
        running_sum_next = running_sum + rx_byte;
        bytes_taken_next = bytes_taken + 8'd1;
        if (bytes_taken_next == len_seen) begin
          phase_next = PH_SUM;
        end
        emit       = 1'b1;
        kind_next  = KIND_BODY;
        index_next = bytes_taken;
        body_next  = rx_byte;
      end
      PH_SUM: begin
        sum_received_next = rx_byte;
        phase_next        = PH_TAIL;
      end
      PH_TAIL: begin
        // Tail is judged before the checksum
        phase_next = PH_HUNT;
        emit       = 1'b1;
        if (rx_byte != tail_byte) begin
          kind_next = KIND_BAD_TAIL;
        end else if (sum_received != running_sum) begin
          kind_next = KIND_BAD_SUM;
        end else begin
          kind_next = KIND_GOOD;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  // ---- State registers ---------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      len_hi_seen  <= '0;
      len_seen     <= '0;
      bytes_taken  <= '0;
      running_sum  <= '0;
      sum_received <= '0;
      ctrl_seen    <= '0;
      id_seen      <= '0;
      cmd_seen     <= '0;
    end else if (in_accept) begin
      phase        <= phase_next;
      len_hi_seen  <= len_hi_seen_next;
      len_seen     <= len_seen_next;
      bytes_taken  <= bytes_taken_next;
      running_sum  <= running_sum_next;
      sum_received <= sum_received_next;
      ctrl_seen    <= ctrl_seen_next;
      id_seen      <= id_seen_next;
      cmd_seen     <= cmd_seen_next;
    end
  end

  // ---- Output register ---------------------------------------------------
  // Load on an accepted item that emits; drop valid once the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_accept && emit) begin
      m_tvalid <= 1'b1;
    end else if (out_take) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      m_tuser <= kind_next;
      m_tdata <= {running_sum_next, len_hi_seen_next, len_seen_next,
                  cmd_seen_next, id_seen_next, ctrl_seen_next,
                  body_next, index_next};
    end
  end

  // ---- Assertions --------------------------------------------------------
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output register empty");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_index_in_body: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_BODY |->
      m_tdata[7:0] < m_tdata[47:40] && m_tdata[47:40] <= MAX_LENGTH)
    else $error("body index outside frame length");

  a_status_length_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_GOOD || m_tuser == KIND_BAD_SUM ||
                 m_tuser == KIND_BAD_TAIL) |->
      m_tdata[47:40] >= MIN_LENGTH && m_tdata[47:40] <= MAX_LENGTH)
    else $error("frame status with out-of-range length");

  a_counter_bounded: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> bytes_taken < len_seen)
    else $error("body counter ran past frame length");

endmodule

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench: self-checking bench for bus_frame_deframer_checksum
// Feeds received bytes through the stream input with random gaps, predicts
// every body-byte and status item, and checks each output item field by
// field while the sink stalls at random. Runs a directed table first, then
// random frames under several header/tail register settings.
// ---------------------------------------------------------------------------
module testbench;
  import bfd_pkg::*;

  localparam int DIRECTED_ROWS  = 30;
  localparam int ITEMS_PER_SET  = 350;
  localparam int SETTLE_CYCLES  = 4;
  localparam int QUIET_LIMIT    = 2000;

  // Frame scan position of the predictor
  typedef enum logic [2:0] {
    SCAN_HUNT, SCAN_LEN_HI, SCAN_LEN, SCAN_BODY, SCAN_CSUM, SCAN_TAIL
  } scan_phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] body_index;
    logic [7:0] body_byte;
    logic [7:0] control_field;
    logic [7:0] station_id;
    logic [7:0] command_code;
    logic [7:0] body_length;
    logic [7:0] length_upper;
    logic [7:0] computed_sum;
  } frame_result_t;

  // One received byte, with a hand-written expectation where typed is set
  typedef struct packed {
    logic [7:0]    rx;
    logic          typed;
    frame_result_t want;
  } rx_item_t;

  localparam frame_result_t NO_RES = '{kind: KIND_BODY, default: 8'h00};

  // Directed bytes, run with header 0x4A and tail 0x3B after reset
  localparam rx_item_t DIRECTED [DIRECTED_ROWS] = '{
    // length 0: flagged at the length byte, captured fields cleared
    '{8'h4A, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'h00, 1'b1, '{kind: KIND_BAD_LEN, body_length: 8'h00, length_upper: 8'hFF,
                     default: 8'h00}},
    // length one above the limit
    '{8'h4A, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h7C, 1'b1, '{kind: KIND_BAD_LEN, body_length: 8'h7C, length_upper: 8'h00,
                     default: 8'h00}},
    // shortest good frame, header value inside the body
    '{8'h4A, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h03, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'h4A, 1'b0, NO_RES},
    '{8'h80, 1'b0, NO_RES},
    '{8'hC9, 1'b0, NO_RES},
    '{8'h3B, 1'b0, NO_RES},
    // wrong checksum, good tail
    '{8'h4A, 1'b0, NO_RES},
    '{8'h01, 1'b0, NO_RES},
    '{8'h03, 1'b0, NO_RES},
    '{8'h01, 1'b0, NO_RES},
    '{8'h02, 1'b0, NO_RES},
    '{8'h03, 1'b0, NO_RES},
    '{8'h07, 1'b0, NO_RES},
    '{8'h3B, 1'b1, '{kind: KIND_BAD_SUM, control_field: 8'h01, station_id: 8'h02,
                     command_code: 8'h03, body_length: 8'h03, length_upper: 8'h01,
                     computed_sum: 8'h06, default: 8'h00}},
    // checksum and tail both wrong: the tail wins
    '{8'h4A, 1'b0, NO_RES},
    '{8'h01, 1'b0, NO_RES},
    '{8'h03, 1'b0, NO_RES},
    '{8'h01, 1'b0, NO_RES},
    '{8'h02, 1'b0, NO_RES},
    '{8'h03, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b1, '{kind: KIND_BAD_TAIL, control_field: 8'h01, station_id: 8'h02,
                     command_code: 8'h03, body_length: 8'h03, length_upper: 8'h01,
                     computed_sum: 8'h06, default: 8'h00}}
  };

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [ADDR_W-1:0]     paddr    = '0;
  logic [31:0]           pwdata   = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata  = '0;   // [7:0] rx_byte
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;         // [7:0] body_index, [15:8] body_byte,
                                          // [23:16] control_field, [31:24] station_id,
                                          // [39:32] command_code, [47:40] body_length,
                                          // [55:48] length_upper, [63:56] computed_sum
  logic [KIND_W-1:0]     m_tuser;         // [2:0] kind

  bus_frame_deframer_checksum dut (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  // Bytes still to send, and results owed by the block, oldest first
  rx_item_t      rx_backlog [$];
  frame_result_t owed_results [$];

  int mismatches  = 0;
  int quiet_cycles = 0;

  // Predictor copy of the registers and of the frame scan state
  logic [7:0]  cfg_header = HEADER_RESET;
  logic [7:0]  cfg_tail   = TAIL_RESET;
  scan_phase_t scan       = SCAN_HUNT;
  logic [7:0]  seen_len_hi, seen_len, taken, body_sum, rx_sum;
  logic [7:0]  seen_ctrl, seen_id, seen_cmd;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------

  function automatic frame_result_t frame_snapshot(kind_t k, logic [7:0] idx,
                                                   logic [7:0] b);
    frame_result_t r;
    r = '{k, idx, b, seen_ctrl, seen_id, seen_cmd, seen_len, seen_len_hi, body_sum};
    return r;
  endfunction

  // Advance the frame scan by one received byte; report the item it causes
  task automatic deframe_predict(input logic [7:0] b, output bit produced,
                                 output frame_result_t r);
    logic [7:0] idx;
    produced = 1'b0;
    r = NO_RES;
    case (scan)
      SCAN_HUNT: begin
        if (b == cfg_header) scan = SCAN_LEN_HI;
      end
      SCAN_LEN_HI: begin
        // Pass the high byte through; it never shapes the length
        seen_len_hi = b;
        scan = SCAN_LEN;
      end
      SCAN_LEN: begin
        seen_len  = b;
        taken     = '0;
        body_sum  = '0;
        rx_sum    = '0;
        seen_ctrl = '0;
        seen_id   = '0;
        seen_cmd  = '0;
        if (b < MIN_LENGTH || b > MAX_LENGTH) begin
          // Flag a bad length at once and go back to hunting
          scan = SCAN_HUNT;
          produced = 1'b1;
          r = frame_snapshot(KIND_BAD_LEN, 8'h00, 8'h00);
        end else begin
          scan = SCAN_BODY;
        end
      end
      SCAN_BODY: begin
        idx = taken;
        if (idx == 8'd0) seen_ctrl = b;
        else if (idx == 8'd1) seen_id = b;
        else if (idx == 8'd2) seen_cmd = b;
        body_sum = body_sum + b;
        taken = idx + 8'd1;
        if (taken == seen_len) scan = SCAN_CSUM;
        produced = 1'b1;
        r = frame_snapshot(KIND_BODY, idx, b);
      end
      SCAN_CSUM: begin
        rx_sum = b;
        scan = SCAN_TAIL;
      end
      SCAN_TAIL: begin
        // Judge the tail before the checksum
        scan = SCAN_HUNT;
        produced = 1'b1;
        if (b != cfg_tail) r = frame_snapshot(KIND_BAD_TAIL, 8'h00, 8'h00);
        else if (rx_sum != body_sum) r = frame_snapshot(KIND_BAD_SUM, 8'h00, 8'h00);
        else r = frame_snapshot(KIND_GOOD, 8'h00, 8'h00);
      end
      default: begin
        scan = SCAN_HUNT;
      end
    endcase
  endtask

  // -------------------------------------------------------------------------
  // Gaps and stalls: mostly none or short, a few long, and now and then a
  // calm stretch with no gap at all
  // -------------------------------------------------------------------------

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // -------------------------------------------------------------------------
  // Byte source: on each accepted item, run the predictor and record what the
  // block owes; then load the next byte once its gap has passed
  // -------------------------------------------------------------------------

  rx_item_t in_flight;
  int       src_gap  = 0;
  int       src_calm = 0;

  always @(posedge clk) begin : byte_source
    bit            produced;
    frame_result_t predicted;
    bit            loaded;
    loaded = s_tvalid;
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        deframe_predict(in_flight.rx, produced, predicted);
        // Prefer the hand-written expectation where the table gives one
        if (in_flight.typed) owed_results.push_back(in_flight.want);
        else if (produced) owed_results.push_back(predicted);
        loaded = 1'b0;
      end
      // Hold the byte until it is taken; otherwise load the next one
      if (!loaded) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (rx_backlog.size() > 0) begin
          in_flight = rx_backlog.pop_front();
          s_tdata  <= in_flight.rx;
          s_tvalid <= 1'b1;
          src_gap = pick_gap(src_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result sink: stall at random
  // -------------------------------------------------------------------------

  int sink_stall = 0;
  int sink_calm  = 0;

  always @(posedge clk) begin : result_sink
    if (rst) begin
      m_tready <= 1'b0;
      sink_stall = 0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      sink_stall = pick_gap(sink_calm);
    end
  end

  // -------------------------------------------------------------------------
  // Result check: compare each accepted item with the oldest owed result
  // -------------------------------------------------------------------------

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (owed_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item, expected none, actual kind %0d data %016h",
                 $time, m_tuser, m_tdata);
      end else begin
        want = owed_results.pop_front();
        compare_field("kind",          8'(want.kind),      {5'b0, m_tuser});
        compare_field("body_index",    want.body_index,    m_tdata[7:0]);
        compare_field("body_byte",     want.body_byte,     m_tdata[15:8]);
        compare_field("control_field", want.control_field, m_tdata[23:16]);
        compare_field("station_id",    want.station_id,    m_tdata[31:24]);
        compare_field("command_code",  want.command_code,  m_tdata[39:32]);
        compare_field("body_length",   want.body_length,   m_tdata[47:40]);
        compare_field("length_upper",  want.length_upper,  m_tdata[55:48]);
        compare_field("computed_sum",  want.computed_sum,  m_tdata[63:56]);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Watchdog: count cycles with no item moving on either side
  // -------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  task automatic queue_byte(input logic [7:0] b);
    rx_item_t it;
    it = '{b, 1'b0, NO_RES};
    rx_backlog.push_back(it);
  endtask

  // Register write: setup cycle, then access cycle
  task automatic reg_write(input logic reg_sel, input logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_markers(input logic [7:0] header, input logic [7:0] tail);
    reg_write(REG_HEADER, header);
    reg_write(REG_TAIL, tail);
    cfg_header = header;
    cfg_tail   = tail;
  endtask

  // Wait until every byte is taken and every owed result has come, then let
  // the pipeline settle so a late or extra item still shows up
  task automatic drain();
    do @(negedge clk);
    while (rx_backlog.size() != 0 || s_tvalid || owed_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly well-formed frames with random content; some with bad lengths,
  // checksums or tails, some cut short, and line noise between them
  task automatic queue_random_frames(input int budget);
    int         sent;
    int         len;
    int         cut;
    int         r;
    logic [7:0] sum;
    logic [7:0] b;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 25)
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
      queue_byte(cfg_header);
      queue_byte(8'($urandom_range(0, 255)));
      r = $urandom_range(0, 99);
      if (r < 8)
        len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2)
                                          : $urandom_range(int'(MAX_LENGTH) + 1, 255);
      else if (r < 85) len = $urandom_range(3, 16);
      else if (r < 97) len = $urandom_range(17, int'(MAX_LENGTH) - 1);
      else len = int'(MAX_LENGTH);
      queue_byte(8'(len));
      sent += 3;
      if (len >= int'(MIN_LENGTH) && len <= int'(MAX_LENGTH)) begin
        sum = 8'h00;
        cut = ($urandom_range(0, 99) < 5) ? $urandom_range(0, len - 1) : len;
        for (int i = 0; i < cut; i++) begin
          b = 8'($urandom_range(0, 255));
          sum = sum + b;
          queue_byte(b);
        end
        sent += cut;
        if (cut == len) begin
          queue_byte(($urandom_range(0, 99) < 80) ? sum
                                                  : sum ^ 8'($urandom_range(1, 255)));
          queue_byte(($urandom_range(0, 99) < 85) ? cfg_tail
                                                  : cfg_tail ^ 8'($urandom_range(1, 255)));
          sent += 2;
        end
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------

  initial begin : main_seq
    logic [7:0] header;
    logic [7:0] tail;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table under the reset register values
    for (int i = 0; i < DIRECTED_ROWS; i++) rx_backlog.push_back(DIRECTED[i]);
    drain();

    // Random frames under extreme, random and reset marker settings
    for (int set = 0; set < 4; set++) begin
      case (set)
        0: begin header = 8'h00; tail = 8'hFF; end
        1: begin header = 8'hFF; tail = 8'h00; end
        2: begin header = 8'($urandom_range(0, 255)); tail = 8'($urandom_range(0, 255)); end
        default: begin header = HEADER_RESET; tail = TAIL_RESET; end
      endcase
      set_markers(header, tail);
      queue_random_frames(ITEMS_PER_SET);
      drain();
    end

    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
